// File: rtl/gbp_pkg.sv
`default_nettype none

package gbp_pkg;

    // Table index width, default for the top level
    localparam int INDEX_BITS_DEF = 12;

    // Configuration port
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int HLEN_W   = 4;
    localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd8;

    // Register indexes, taken from paddr[2]
    localparam logic REG_HISTORY_BITS = 1'b0;

    // Counter value written by the clearing pass: weakly taken
    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;
    localparam logic [1:0] CTR_MIN        = 2'd0;

    typedef struct packed {
        logic [31:0] branch_address;
        logic        actual_taken;
    } t_in;

    typedef struct packed {
        logic        predicted_taken;
        logic        mispredicted;
        logic [31:0] miss_total;
    } t_out;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

endpackage

`default_nettype wire

// File: rtl/gbp_out_queue.sv
`default_nettype none

module gbp_out_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gbp_pkg::t_out i_data,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output gbp_pkg::t_out      o_data
);

    gbp_pkg::t_out r_head;
    gbp_pkg::t_out r_tail;
    logic [1:0]    r_cnt;
    logic          w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_head;
    // Leave room for one more transaction while one waits
    assign o_room  = (r_cnt != 2'd2);

    // Track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Move entries towards the head
    always_ff @(posedge i_clk) begin
        if (i_push && !w_pop) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_tail <= i_data;
            end
        end else if (i_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_head <= i_data;
            end else begin
                r_head <= r_tail;
                r_tail <= i_data;
            end
        end else if (w_pop) begin
            r_head <= r_tail;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gshare_branch_predictor_unit.sv
`default_nettype none
// Result path: the counter for the accepted branch is read into a register, then the
// write-back updates it and loads the output queue, from which the result is taken.
// Issue: no new read is issued until the write-back of the previous branch has landed
// (a zero address is accepted but gives no result).
// Reset: synchronous, active low; history and miss count clear, then a clearing
// pass sets every counter to weakly taken (input stalled).

module gshare_branch_predictor_unit #(
    parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire gbp_pkg::t_in               i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output gbp_pkg::t_out                   o_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gbp_pkg::CFG_AW-1:0] paddr,
    input  wire logic [gbp_pkg::CFG_DW-1:0] pwdata,
    output logic      [gbp_pkg::CFG_DW-1:0] prdata,
    output logic                            pready
);

    localparam int DEPTH = 2 ** INDEX_BITS;
    localparam int LEN_W = $clog2(INDEX_BITS + 1);

    gbp_pkg::t_state r_state, n_state;

    logic [gbp_pkg::HLEN_W-1:0] r_hist_len;
    logic [INDEX_BITS-1:0]      r_hist, n_hist;
    logic [INDEX_BITS-1:0]      r_clr_addr;
    logic [31:0]                r_miss, n_miss;
    logic [INDEX_BITS-1:0]      r_idx;
    logic                       r_taken;
    logic [1:0]                 r_rdata;

    logic [1:0]                 mem [DEPTH];

    logic [LEN_W-1:0]           w_len;
    logic [LEN_W-1:0]           w_sh;
    logic [INDEX_BITS-1:0]      w_hmask;
    logic [INDEX_BITS-1:0]      w_hist;
    logic [INDEX_BITS-1:0]      w_idx;
    logic                       w_accept;
    logic                       w_start;
    logic                       w_room;
    logic                       w_we;
    logic [INDEX_BITS-1:0]      w_waddr;
    logic [1:0]                 w_wdata;
    logic [1:0]                 w_ctr_new;
    logic                       w_pred;
    logic                       w_miss;
    logic                       w_push;
    gbp_pkg::t_out              w_res;

    // Configuration port
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == gbp_pkg::REG_HISTORY_BITS) begin
            prdata = {{(gbp_pkg::CFG_DW - gbp_pkg::HLEN_W){1'b0}}, r_hist_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len <= gbp_pkg::HLEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == gbp_pkg::REG_HISTORY_BITS)) begin
            r_hist_len <= pwdata[gbp_pkg::HLEN_W-1:0];
        end
    end

    // Saturate history length to 1..INDEX_BITS
    always_comb begin
        if (r_hist_len == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_hist_len) > INDEX_BITS) begin
            w_len = LEN_W'(INDEX_BITS);
        end else begin
            w_len = LEN_W'(r_hist_len);
        end
    end

    assign w_sh    = LEN_W'(INDEX_BITS) - w_len;
    assign w_hmask = {INDEX_BITS{1'b1}} >> w_sh;
    assign w_hist  = r_hist & w_hmask;
    // Fold history into the top index bits
    assign w_idx   = i_in_data.branch_address[INDEX_BITS+1:2] ^ (w_hist << w_sh);

    assign o_in_ready = (r_state == gbp_pkg::ST_IDLE) && w_room;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && (i_in_data.branch_address != 32'd0);

    // Next history: shift right, outcome enters at the top of the active length
    always_comb begin
        n_hist = r_hist;
        if (w_start) begin
            n_hist = ((w_hist >> 1)
                      | (i_in_data.actual_taken ? (INDEX_BITS'(1) << (w_len - LEN_W'(1)))
                                                : '0))
                     & w_hmask;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbp_pkg::ST_CLEAR: begin
                if (r_clr_addr == {INDEX_BITS{1'b1}}) begin
                    n_state = gbp_pkg::ST_IDLE;
                end
            end
            gbp_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state = gbp_pkg::ST_BUSY;
                end
            end
            gbp_pkg::ST_BUSY: begin
                n_state = gbp_pkg::ST_IDLE;
            end
            default: begin
                n_state = gbp_pkg::ST_CLEAR;
            end
        endcase
    end

    // Counter update and prediction from the read data
    assign w_pred = r_rdata[1];
    assign w_miss = (w_pred != r_taken);

    always_comb begin
        w_ctr_new = r_rdata;
        if (r_taken) begin
            if (r_rdata != gbp_pkg::CTR_MAX) begin
                w_ctr_new = r_rdata + 2'd1;
            end
        end else begin
            if (r_rdata != gbp_pkg::CTR_MIN) begin
                w_ctr_new = r_rdata - 2'd1;
            end
        end
    end

    assign w_push = (r_state == gbp_pkg::ST_BUSY);
    assign n_miss = r_miss + {31'd0, w_miss};

    // Memory write port: clearing pass or write-back
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_ctr_new;
        if (r_state == gbp_pkg::ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = gbp_pkg::CTR_WEAK_TAKEN;
        end else if (w_push) begin
            w_we = 1'b1;
        end
    end

    // Counter memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_start) begin
            r_rdata <= mem[w_idx];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_hist     <= '0;
            r_miss     <= 32'd0;
        end else begin
            if (r_state == gbp_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + INDEX_BITS'(1);
            end
            r_hist <= n_hist;
            if (w_push) begin
                r_miss <= n_miss;
            end
        end
    end

    // Hold the branch in flight
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_idx   <= w_idx;
            r_taken <= i_in_data.actual_taken;
        end
    end

    always_comb begin
        w_res.predicted_taken = w_pred;
        w_res.mispredicted    = w_miss;
        w_res.miss_total      = n_miss;
    end

    gbp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: rtl/gbp_checker.sv
`default_nettype none

module gbp_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       o_in_ready,
    input  wire gbp_pkg::t_in               i_in_data,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    input  wire gbp_pkg::t_out              o_out_data,
    input  wire logic                       pready
);

    // Clearing pass holds off input right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing pass");

    // No result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // A live branch occupies the counter memory for the next cycle
    a_rmw_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.branch_address != 32'd0))
        |=> !o_in_ready)
        else $error("new transaction accepted during write-back");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind gshare_branch_predictor_unit gbp_checker u_gbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);

`default_nettype wire
